[rtl/core/shpc_pkg.sv]
package shpc_pkg;

   // Default sizes, handed to the top level parameters
   localparam int SPEED_BITS_DEF = 16;
   localparam int TICK_BITS_DEF  = 16;

   // Pedal positions and config registers are Q0.16
   localparam int PEDAL_W    = 16;
   // Tick count is multiplied in chunks of this many bits
   localparam int DIGIT_W    = 16;
   // |dv| * 2 * 65536
   localparam int LEFT_SHIFT = 17;

   localparam int CFG_IDX_W  = 3;
   localparam int UPC_W      = 3;

   localparam logic [CFG_IDX_W-1:0] REG_GAS_STEP       = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_BRAKE_STEP     = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_BRAKE_RELEASE  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_GAS_ACTIVE     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 3'd4;

   localparam logic [PEDAL_W-1:0] GAS_STEP_RST      = 16'd655;
   localparam logic [PEDAL_W-1:0] BRAKE_STEP_RST    = 16'd1966;
   localparam logic [PEDAL_W-1:0] BRAKE_RELEASE_RST = 16'd655;
   localparam logic [PEDAL_W-1:0] GAS_ACTIVE_RST    = 16'd328;
   localparam logic [PEDAL_W-1:0] TICK_PERIOD_RST   = 16'd655;

   localparam logic PEDAL_GAS   = 1'b0;
   localparam logic PEDAL_BRAKE = 1'b1;

   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_TOGGLE = 1'b1;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_UPDATE,
      OP_MUL_PERIOD,
      OP_MUL_TICK,
      OP_ACCUM,
      OP_DECIDE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_NO_DECISION,
      C_MORE_DIGITS,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
   } ucode_word_type;

   localparam logic [UPC_W-1:0] UPC_IDLE     = 3'd0;
   localparam logic [UPC_W-1:0] UPC_MUL_TICK = 3'd3;
   localparam logic [UPC_W-1:0] UPC_DECIDE   = 3'd5;

   // Control store: jump to target when cond holds, else fall through
   function automatic ucode_word_type ucode_rom(input logic [UPC_W-1:0] addr);
      ucode_word_type w;
      case (addr)
         3'd0:    w = '{op: OP_LOAD,       cond: C_NO_ACCEPT,   target: UPC_IDLE};
         3'd1:    w = '{op: OP_UPDATE,     cond: C_NO_DECISION, target: UPC_IDLE};
         3'd2:    w = '{op: OP_MUL_PERIOD, cond: C_NEVER,       target: UPC_IDLE};
         3'd3:    w = '{op: OP_MUL_TICK,   cond: C_NEVER,       target: UPC_IDLE};
         3'd4:    w = '{op: OP_ACCUM,      cond: C_MORE_DIGITS, target: UPC_MUL_TICK};
         3'd5:    w = '{op: OP_DECIDE,     cond: C_OUT_BUSY,    target: UPC_DECIDE};
         3'd6:    w = '{op: OP_EMIT,       cond: C_ALWAYS,      target: UPC_IDLE};
         default: w = '{op: OP_NOP,        cond: C_ALWAYS,      target: UPC_IDLE};
      endcase
      return w;
   endfunction

endpackage

[rtl/core/speed_hold_pedal_controller_top.sv]
// Channel  Handshake                Payload
// req      req_tvalid/req_tready    tuser: kind; tdata: speeds, gas, brake
// rsp      rsp_tvalid/rsp_tready    tuser: pedal; tdata: command_value
// csr      csr_valid/csr_ready      csr_index, csr_data
//
// Toggles, released ticks, unchanged ticks and on-target ticks end after accept and update.
// A changed tick off target steps through accept, update, err*period, one multiply and
// accumulate per 16-bit tick chunk, decide and emit.
// Reset clears the hold, the tick count (to 1) and loads config defaults.
// A stalled rsp holds the sequencer at its decide step; req is taken again
// while a finished word still waits on rsp.
module speed_hold_pedal_controller_top #(
   parameter int SPEED_BITS = shpc_pkg::SPEED_BITS_DEF,
   parameter int TICK_BITS  = shpc_pkg::TICK_BITS_DEF,
   localparam int REQ_DATA_W = ((2 * SPEED_BITS + 2 * shpc_pkg::PEDAL_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // kind
   input  logic [0:0]                        req_tuser,
   // left_rear_speed, right_rear_speed, gas_position, brake_position, zero pad
   input  logic [REQ_DATA_W-1:0]             req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pedal
   output logic [0:0]                        rsp_tuser,
   // command_value
   output logic [shpc_pkg::PEDAL_W-1:0]      rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [shpc_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [shpc_pkg::PEDAL_W-1:0]      csr_data
);
   import shpc_pkg::*;

   localparam int SUM_W  = SPEED_BITS + 1;
   localparam int DIFF_W = SPEED_BITS + 2;
   localparam int MAG_W  = SPEED_BITS + 1;
   localparam int P1_W   = MAG_W + PEDAL_W;
   localparam int MUL_W  = P1_W + DIGIT_W;
   localparam int DIGITS = (TICK_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam int TPAD_W = DIGITS * DIGIT_W;
   localparam int ACC_W  = P1_W + TPAD_W;
   localparam int DIG_CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   // config
   logic [PEDAL_W-1:0] gas_step_ff, brake_step_ff, brake_release_ff;
   logic [PEDAL_W-1:0] gas_active_ff, tick_period_ff;

   // sequencer
   logic [UPC_W-1:0] upc_ff, upc_in;
   ucode_word_type   cw;
   logic             jump;

   // architectural state
   logic                    engaged_ff, engaged_in;
   logic signed [SUM_W-1:0] target_ff, target_in;
   logic signed [SUM_W-1:0] last_ff, last_in;
   logic [TICK_BITS-1:0]    ticks_ff, ticks_in;

   // item word
   logic                    kind_ff, kind_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PEDAL_W-1:0]      gas_ff, gas_in, brake_ff, brake_in;

   // datapath
   logic                 dv_neg_ff, dv_neg_in, err_neg_ff, err_neg_in;
   logic [MAG_W-1:0]     adv_ff, adv_in, aerr_ff, aerr_in;
   logic [TPAD_W-1:0]    tick_pad_ff, tick_pad_in;
   logic [P1_W-1:0]      p1_ff, p1_in;
   logic [MUL_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [DIG_CW-1:0]    dig_ff, dig_in;
   logic                 res_hit_ff, res_hit_in, res_pedal_ff, res_pedal_in;
   logic [PEDAL_W-1:0]   res_value_ff, res_value_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in, rsp_pedal_ff, rsp_pedal_in;
   logic [PEDAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                     req_accept;
   logic signed [SPEED_BITS-1:0] left_s, right_s;
   logic signed [DIFF_W-1:0] dv, err;
   logic                     no_decision, more_digits, out_busy, fast;
   logic [P1_W-1:0]          mul_a;
   logic [DIGIT_W-1:0]       mul_b, tick_digit;
   logic [MUL_W-1:0]         mul_out;
   logic [ACC_W-1:0]         left_ext;
   logic [PEDAL_W:0]         gas_up, brake_up;

   assign cw         = ucode_rom(upc_ff);
   assign req_tready = (upc_ff == UPC_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign left_s  = req_tdata[SPEED_BITS-1:0];
   assign right_s = req_tdata[2*SPEED_BITS-1:SPEED_BITS];
   assign sum_in  = SUM_W'(left_s) + SUM_W'(right_s);
   assign kind_in  = req_tuser[0];
   assign gas_in   = req_tdata[2*SPEED_BITS +: PEDAL_W];
   assign brake_in = req_tdata[2*SPEED_BITS+PEDAL_W +: PEDAL_W];

   assign dv  = DIFF_W'(sum_ff) - DIFF_W'(last_ff);
   assign err = DIFF_W'(target_ff) - DIFF_W'(sum_ff);

   assign no_decision = (kind_ff == KIND_TOGGLE) || !engaged_ff || (dv == '0) || (err == '0);
   assign more_digits = (dig_ff != DIG_CW'(DIGITS - 1));
   assign out_busy    = rsp_valid_ff && !rsp_tready;

   // one shared multiplier: err * period first, then err*period * tick chunk
   assign tick_digit = tick_pad_ff[dig_ff*DIGIT_W +: DIGIT_W];
   assign mul_a   = (cw.op == OP_MUL_TICK) ? p1_ff : P1_W'(aerr_ff);
   assign mul_b   = (cw.op == OP_MUL_TICK) ? tick_digit : tick_period_ff;
   assign mul_out = MUL_W'(mul_a) * MUL_W'(mul_b);

   // fast when |err|*period*ticks < |dv|*2^17
   assign left_ext = ACC_W'(adv_ff) << LEFT_SHIFT;
   assign fast     = (acc_ff < left_ext);

   assign gas_up   = {1'b0, gas_ff} + {1'b0, gas_step_ff};
   assign brake_up = {1'b0, brake_ff} + {1'b0, brake_step_ff};

   always_comb begin
      case (cw.cond)
         C_NEVER:       jump = 1'b0;
         C_ALWAYS:      jump = 1'b1;
         C_NO_ACCEPT:   jump = !req_accept;
         C_NO_DECISION: jump = no_decision;
         C_MORE_DIGITS: jump = more_digits;
         C_OUT_BUSY:    jump = out_busy;
         default:       jump = 1'b1;
      endcase
      upc_in = jump ? cw.target : upc_ff + UPC_W'(1);
   end

   always_comb begin
      engaged_in   = engaged_ff;
      target_in    = target_ff;
      last_in      = last_ff;
      ticks_in     = ticks_ff;
      dv_neg_in    = dv_neg_ff;
      err_neg_in   = err_neg_ff;
      adv_in       = adv_ff;
      aerr_in      = aerr_ff;
      tick_pad_in  = tick_pad_ff;
      p1_in        = p1_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      dig_in       = dig_ff;
      res_hit_in   = res_hit_ff;
      res_pedal_in = res_pedal_ff;
      res_value_in = res_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pedal_in = rsp_pedal_ff;
      rsp_value_in = rsp_value_ff;

      case (cw.op)
         OP_UPDATE: begin
            dv_neg_in   = dv[DIFF_W-1];
            err_neg_in  = err[DIFF_W-1];
            adv_in      = dv[DIFF_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
            aerr_in     = err[DIFF_W-1] ? MAG_W'(-err) : MAG_W'(err);
            tick_pad_in = TPAD_W'(ticks_ff);
            acc_in      = '0;
            dig_in      = '0;
            if (kind_ff == KIND_TOGGLE) begin
               engaged_in = !engaged_ff;
               if (!engaged_ff) begin
                  target_in = sum_ff;
                  last_in   = sum_ff;
                  ticks_in  = TICK_BITS'(1);
               end
            end else if (engaged_ff) begin
               if (dv == '0) begin
                  if (!(&ticks_ff)) begin
                     ticks_in = ticks_ff + TICK_BITS'(1);
                  end
               end else begin
                  last_in  = sum_ff;
                  ticks_in = TICK_BITS'(1);
               end
            end
         end
         OP_MUL_PERIOD: p1_in   = mul_out[P1_W-1:0];
         OP_MUL_TICK:   prod_in = mul_out;
         OP_ACCUM: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) << (dig_ff * DIGIT_W));
            if (more_digits) begin
               dig_in = dig_ff + DIG_CW'(1);
            end
         end
         OP_DECIDE: begin
            // same signs of err and dv: act only when closing in too fast
            res_hit_in = (err_neg_ff != dv_neg_ff) || fast;
            if (dv_neg_ff) begin
               if (brake_ff > brake_release_ff) begin
                  res_pedal_in = PEDAL_BRAKE;
                  res_value_in = '0;
               end else begin
                  res_pedal_in = PEDAL_GAS;
                  res_value_in = gas_up[PEDAL_W] ? '1 : gas_up[PEDAL_W-1:0];
               end
            end else begin
               if (gas_ff > gas_active_ff) begin
                  res_pedal_in = PEDAL_GAS;
                  res_value_in = (gas_ff > brake_step_ff) ? gas_ff - brake_step_ff : '0;
               end else begin
                  res_pedal_in = PEDAL_BRAKE;
                  res_value_in = brake_up[PEDAL_W] ? '1 : brake_up[PEDAL_W-1:0];
               end
            end
         end
         OP_EMIT: begin
            rsp_valid_in = res_hit_ff;
            rsp_pedal_in = res_pedal_ff;
            rsp_value_in = res_value_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff           <= UPC_IDLE;
         engaged_ff       <= 1'b0;
         target_ff        <= '0;
         last_ff          <= '0;
         ticks_ff         <= TICK_BITS'(1);
         rsp_valid_ff     <= 1'b0;
         gas_step_ff      <= GAS_STEP_RST;
         brake_step_ff    <= BRAKE_STEP_RST;
         brake_release_ff <= BRAKE_RELEASE_RST;
         gas_active_ff    <= GAS_ACTIVE_RST;
         tick_period_ff   <= TICK_PERIOD_RST;
      end else begin
         upc_ff       <= upc_in;
         engaged_ff   <= engaged_in;
         target_ff    <= target_in;
         last_ff      <= last_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GAS_STEP:      gas_step_ff      <= csr_data;
               REG_BRAKE_STEP:    brake_step_ff    <= csr_data;
               REG_BRAKE_RELEASE: brake_release_ff <= csr_data;
               REG_GAS_ACTIVE:    gas_active_ff    <= csr_data;
               REG_TICK_PERIOD:   tick_period_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cw.op == OP_LOAD && req_accept) begin
         kind_ff  <= kind_in;
         sum_ff   <= sum_in;
         gas_ff   <= gas_in;
         brake_ff <= brake_in;
      end
      dv_neg_ff    <= dv_neg_in;
      err_neg_ff   <= err_neg_in;
      adv_ff       <= adv_in;
      aerr_ff      <= aerr_in;
      tick_pad_ff  <= tick_pad_in;
      p1_ff        <= p1_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      dig_ff       <= dig_in;
      res_hit_ff   <= res_hit_in;
      res_pedal_ff <= res_pedal_in;
      res_value_ff <= res_value_in;
      rsp_pedal_ff <= rsp_pedal_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_pedal_ff;
   assign rsp_tdata    = rsp_value_ff;

`ifndef SYNTHESIS
   a_ticks_nonzero: assert property (@(posedge clock) disable iff (reset)
      ticks_ff != '0)
      else $error("unchanged tick count reached zero");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_EMIT) |-> !rsp_valid_ff)
      else $error("emit step would overwrite a pending response");

   a_mul_operands: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_MUL_PERIOD) |-> (adv_ff != '0) && (aerr_ff != '0) && engaged_ff)
      else $error("multiply pass entered without a speed change and error");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_MUL_TICK) |-> (dig_ff <= DIG_CW'(DIGITS - 1)))
      else $error("tick chunk index out of range");
`endif

endmodule
